// ===== design/epi_pkg.sv =====
// Shared types and codes for the envelope point interpolator.
package epi_pkg;

   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_WRITE   = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [1:0] CSR_NODES_USED      = 2'd0;
   localparam logic [1:0] CSR_SUSTAIN_ENABLE  = 2'd1;
   localparam logic [1:0] CSR_LOOP_START_NODE = 2'd2;
   localparam logic [1:0] CSR_LOOP_END_TICK   = 2'd3;

   localparam int INDEX_LIMIT = 16;

   typedef struct packed {
      logic [15:0]        start_tick;
      logic [7:0]         level;
      logic signed [16:0] slope;
   } node_entry_type;

   typedef struct packed {
      logic [4:0]  nodes_used;
      logic        sustain_enable;
      logic [3:0]  loop_start_node;
      logic [15:0] loop_end_tick;
   } cfg_type;

   typedef struct packed {
      logic [3:0] loop_addr;
      logic [3:0] next_addr;
   } tick_addr_type;

   typedef struct packed {
      logic [15:0] loop_tick;
      logic [15:0] next_tick;
   } tick_read_type;

endpackage

// ===== design/epi_node_table.sv =====
// Node table register file with one entry read port and two start-tick read ports.
module epi_node_table
   import epi_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic           clock,
   input  logic           write_enable,
   input  logic [3:0]     write_index,
   input  node_entry_type write_entry,
   input  logic [3:0]     node_addr,
   input  tick_addr_type  tick_addr,
   output node_entry_type node_entry,
   output tick_read_type  tick_read
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   node_entry_type entry_ff [DEPTH];

   function automatic logic in_range(input logic [3:0] idx);
      in_range = {1'b0, idx} < 5'(DEPTH);
   endfunction

   always_ff @(posedge clock) begin
      if (write_enable && in_range(write_index)) begin
         entry_ff[write_index[AW-1:0]] <= write_entry;
      end
   end

   always_comb begin
      node_entry = '0;
      tick_read  = '0;
      if (in_range(node_addr)) begin
         node_entry = entry_ff[node_addr[AW-1:0]];
      end
      if (in_range(tick_addr.loop_addr)) begin
         tick_read.loop_tick = entry_ff[tick_addr.loop_addr[AW-1:0]].start_tick;
      end
      if (in_range(tick_addr.next_addr)) begin
         tick_read.next_tick = entry_ff[tick_addr.next_addr[AW-1:0]].start_tick;
      end
   end

endmodule

// ===== design/epi_sampler.sv =====
// Linear interpolation of one node segment, scaling and clamping to ten bits.
module epi_sampler
   import epi_pkg::*;
(
   input  logic [15:0]    tick,
   input  node_entry_type entry,
   output logic [9:0]     envelope_value
);

   logic signed [16:0] diff;
   logic signed [33:0] product;
   logic signed [24:0] shifted;
   logic signed [25:0] total;

   assign diff    = $signed({1'b0, tick}) - $signed({1'b0, entry.start_tick});
   assign product = entry.slope * diff;
   assign shifted = product[33:9];
   assign total   = {shifted[24], shifted} + $signed({18'd0, entry.level});

   always_comb begin
      if (total[25]) begin
         envelope_value = '0;
      end else if (total > 26'sd255) begin
         envelope_value = '1;
      end else begin
         envelope_value = {total[7:0], 2'b00};
      end
   end

endmodule

// ===== design/epi_position.sv =====
// Envelope position state: tick advance, sustain loop wrap and node stepping.
module epi_position
   import epi_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          restart,
   input  logic          held,
   input  cfg_type       cfg,
   input  tick_read_type tick_read,
   output tick_addr_type tick_addr,
   output logic [3:0]    node,
   output logic [15:0]   tick
);

   logic [3:0]  node_ff, node_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  last_node;
   logic [3:0]  loop_node;
   logic [15:0] tick_inc;
   logic        jump;
   logic [3:0]  node_j;
   logic [15:0] tick_j;
   logic        step;

   always_comb begin
      if (cfg.nodes_used == 5'd0) begin
         last_node = 4'd0;
      end else if (cfg.nodes_used > 5'(DEPTH)) begin
         last_node = 4'(DEPTH - 1);
      end else begin
         last_node = 4'(cfg.nodes_used - 5'd1);
      end
   end

   assign loop_node = (cfg.loop_start_node > last_node) ? last_node : cfg.loop_start_node;
   assign tick_inc  = (tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;
   assign jump      = cfg.sustain_enable && held && (tick_inc >= cfg.loop_end_tick);
   assign node_j    = jump ? loop_node : node_ff;
   assign tick_j    = jump ? tick_read.loop_tick : tick_inc;

   assign tick_addr.loop_addr = loop_node;
   assign tick_addr.next_addr = node_j + 4'd1;

   assign step = (node_j < last_node) && (tick_j >= tick_read.next_tick);

   always_comb begin
      node_in = node_ff;
      tick_in = tick_ff;
      if (restart) begin
         node_in = '0;
         tick_in = '0;
      end else if (advance) begin
         node_in = step ? node_j + 4'd1 : node_j;
         tick_in = tick_j;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         tick_ff <= '0;
      end else begin
         node_ff <= node_in;
         tick_ff <= tick_in;
      end
   end

   assign node = node_ff;
   assign tick = tick_ff;

endmodule

// ===== design/envelope_point_interpolator.sv =====
// Top level of the envelope point interpolator: request stage, table, position and result.
//
//   Channel   Handshake          Payload
//   req       req_valid/ready    action, sustain_held, node_index, node_start_tick,
//                                node_level, node_slope
//   rsp       rsp_valid/ready    envelope_value, node_position (tick requests only)
//   csr       csr_write_enable   csr_index, csr_write_data
//
// A request is registered on acceptance and processed once it can fire; a tick result is
// then registered in the result stage. One request per cycle while no result is held back;
// each request makes a single pass through the slope multiplier and position update.
// Reset clears the position and both handshake stages and sets nodes_used to one in the configuration.
// A tick request waits in the request stage while a result is held back by rsp_ready.
module envelope_point_interpolator
   import epi_pkg::*;
#(
   parameter int MAX_NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic               req_sustain_held,
   input  logic [3:0]         req_node_index,
   input  logic [15:0]        req_node_start_tick,
   input  logic [7:0]         req_node_level,
   input  logic signed [16:0] req_node_slope,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_envelope_value,
   output logic [3:0]         rsp_node_position,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   localparam int TABLE_DEPTH = (MAX_NODES > INDEX_LIMIT) ? INDEX_LIMIT : MAX_NODES;

   cfg_type cfg_ff, cfg_in;

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_action_ff;
   logic               in_held_ff;
   logic [3:0]         in_index_ff;
   node_entry_type     in_entry_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_value_ff;
   logic [3:0]         rsp_node_ff;

   logic               is_tick;
   logic               fire;
   logic               take;
   node_entry_type     node_entry;
   tick_addr_type      tick_addr;
   tick_read_type      tick_read;
   logic [3:0]         position_node;
   logic [15:0]        position_tick;
   logic [9:0]         sample_value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NODES_USED:      cfg_in.nodes_used      = csr_write_data[4:0];
            CSR_SUSTAIN_ENABLE:  cfg_in.sustain_enable  = csr_write_data[0];
            CSR_LOOP_START_NODE: cfg_in.loop_start_node = csr_write_data[3:0];
            CSR_LOOP_END_TICK:   cfg_in.loop_end_tick   = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nodes_used      <= 5'd1;
         cfg_ff.sustain_enable  <= 1'b0;
         cfg_ff.loop_start_node <= '0;
         cfg_ff.loop_end_tick   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign is_tick   = in_action_ff == ACT_TICK;
   assign fire      = in_valid_ff && (!is_tick || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign rsp_valid_in = (fire && is_tick) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_action_ff           <= req_action;
         in_held_ff             <= req_sustain_held;
         in_index_ff            <= req_node_index;
         in_entry_ff.start_tick <= req_node_start_tick;
         in_entry_ff.level      <= req_node_level;
         in_entry_ff.slope      <= req_node_slope;
      end
      if (fire && is_tick) begin
         rsp_value_ff <= sample_value;
         rsp_node_ff  <= position_node;
      end
   end

   epi_node_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock       (clock),
      .write_enable(fire && (in_action_ff == ACT_WRITE)),
      .write_index (in_index_ff),
      .write_entry (in_entry_ff),
      .node_addr   (position_node),
      .tick_addr   (tick_addr),
      .node_entry  (node_entry),
      .tick_read   (tick_read)
   );

   epi_position #(
      .DEPTH(TABLE_DEPTH)
   ) u_position (
      .clock    (clock),
      .reset    (reset),
      .advance  (fire && is_tick),
      .restart  (fire && (in_action_ff == ACT_RESTART)),
      .held     (in_held_ff),
      .cfg      (cfg_ff),
      .tick_read(tick_read),
      .tick_addr(tick_addr),
      .node     (position_node),
      .tick     (position_tick)
   );

   epi_sampler u_sampler (
      .tick          (position_tick),
      .entry         (node_entry),
      .envelope_value(sample_value)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_envelope_value = rsp_value_ff;
   assign rsp_node_position  = rsp_node_ff;

endmodule

// ===== design/epi_checker.sv =====
// Port-level checks for the envelope point interpolator, bound to the top level.
module epi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [9:0]         rsp_envelope_value,
   input logic [3:0]         rsp_node_position
);

   // A result is never present in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid directly after reset.");

   // A held result keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_envelope_value) && $stable(rsp_node_position))
      else $error("Held result changed before it was taken.");

   // The request side only stalls behind a result that is being held back.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("Request stalled without a blocked result.");

   // A rising result requires that reset was already low when its request was accepted.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!reset, 2))
      else $error("Result appeared too soon after reset.");

endmodule

bind envelope_point_interpolator epi_checker u_epi_checker (.*);
